// ===== rtl/core/ising_pkg.sv =====
// Shared types and constants for the Ising lattice site-update block.
// Holds the controller state type, the flip decision struct and field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ising_pkg;

    // Field widths of the word interfaces
    localparam int SITE_W = 4;
    localparam int FRAC_W = 16;
    localparam int DE_W   = 5;
    localparam int MAG_W  = 10;
    localparam int ENG_W  = 11;

    // Number of distinct values a site index field can carry
    localparam int SITE_CODES = 1 << SITE_W;

    // Configuration register indexes
    localparam logic CFG_DE4 = 1'b0;
    localparam logic CFG_DE8 = 1'b1;

    // Reset values of the acceptance fractions
    localparam logic [FRAC_W-1:0] FRAC_DE4_RST = 16'd1200;
    localparam logic [FRAC_W-1:0] FRAC_DE8_RST = 16'd22;

    // Energy changes that need a random draw
    localparam logic signed [DE_W-1:0] DE_FOUR  = 5'sd4;
    localparam logic signed [DE_W-1:0] DE_EIGHT = 5'sd8;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_CTR,
        ST_EVAL
    } t_state;

    // Decision for one site visit
    typedef struct packed {
        logic                   flip;
        logic                   spin_after;
        logic signed [DE_W-1:0] de;
    } t_eval;

endpackage

`default_nettype wire

// ===== rtl/core/ising_lattice_mem.sv =====
// Row-organized spin memory: one word per lattice row, one bit per column.
// Two registered read ports and one write port. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module ising_lattice_mem #(
    parameter int SIDE  = 16,
    parameter int IDX_W = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rd_en_a,
    input  wire logic [IDX_W-1:0] i_rd_addr_a,
    output logic      [SIDE-1:0]  o_rd_data_a,
    input  wire logic             i_rd_en_b,
    input  wire logic [IDX_W-1:0] i_rd_addr_b,
    output logic      [SIDE-1:0]  o_rd_data_b,
    input  wire logic             i_wr_en,
    input  wire logic [IDX_W-1:0] i_wr_addr,
    input  wire logic [SIDE-1:0]  i_wr_data
);

    logic [SIDE-1:0] r_mem [SIDE];

    // Write one row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read two rows, hold data while a port is not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en_a) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
        end
        if (i_rd_en_b) begin
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ising_flip_eval.sv =====
// Metropolis decision for one site: energy change and acceptance test.
// Depends on ising_pkg for widths, constants and the t_eval struct.
`timescale 1ns / 1ps
`default_nettype none

module ising_flip_eval
    import ising_pkg::*;
(
    input  wire logic              i_spin,
    input  wire logic              i_up,
    input  wire logic              i_down,
    input  wire logic              i_left,
    input  wire logic              i_right,
    input  wire logic [FRAC_W-1:0] i_rnd,
    input  wire logic [FRAC_W-1:0] i_frac_de4,
    input  wire logic [FRAC_W-1:0] i_frac_de8,
    output t_eval                  o_eval
);

    logic       [2:0]      w_ones;
    logic signed [DE_W:0]  w_sum2;
    logic signed [DE_W:0]  w_de_wide;
    logic signed [DE_W-1:0] w_de;
    logic                  w_accept;

    // Count up neighbors; 2*sum = 4*ones - 8
    always_comb begin
        w_ones    = 3'(i_up) + 3'(i_down) + 3'(i_left) + 3'(i_right);
        w_sum2    = $signed({1'b0, w_ones, 2'b00}) - 6'sd8;
        w_de_wide = i_spin ? w_sum2 : -w_sum2;
        w_de      = w_de_wide[DE_W-1:0];
    end

    // Accept any drop, draw against the fraction for a rise
    always_comb begin
        if (w_de <= 5'sd0) begin
            w_accept = 1'b1;
        end else if (w_de == DE_FOUR) begin
            w_accept = i_rnd < i_frac_de4;
        end else begin
            w_accept = i_rnd < i_frac_de8;
        end
    end

    always_comb begin
        o_eval.flip       = w_accept;
        o_eval.spin_after = i_spin ^ w_accept;
        o_eval.de         = w_de;
    end

endmodule

`default_nettype wire

// ===== rtl/core/ising_metropolis_site_update.sv =====
// Single-site Metropolis update of a SIDE x SIDE Ising lattice with wrapped edges.
// After reset a clearing pass sets every spin to +1; no word is accepted until it
// ends. Each visit then passes through ST_IDLE, ST_READ_CTR and ST_EVAL, and
// ST_EVAL waits out any output stall: the row memory has two read ports and a
// visit needs three rows (the rows above and below in ST_IDLE, the site's own
// row in ST_READ_CTR); ST_EVAL decides, writes the row back on a flip and loads
// the result word. The result register lets the next word be accepted while a
// result waits. Depends on ising_pkg, ising_lattice_mem and ising_flip_eval.
`timescale 1ns / 1ps
`default_nettype none

module ising_metropolis_site_update
    import ising_pkg::*;
#(
    parameter int SIDE = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Configuration
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_index,
    input  wire logic [FRAC_W-1:0]        i_cfg_data,
    // Input words
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [SITE_W-1:0]        i_site_row,
    input  wire logic [SITE_W-1:0]        i_site_col,
    input  wire logic [FRAC_W-1:0]        i_random_fraction,
    // Result words
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic                          o_flipped,
    output logic                          o_spin_after,
    output logic signed [DE_W-1:0]        o_energy_change,
    output logic signed [MAG_W-1:0]       o_magnetization,
    output logic signed [ENG_W-1:0]       o_total_energy
);

    localparam int IDX_W = $clog2(SIDE);
    localparam int CELLS = SIDE * SIDE;
    localparam logic [IDX_W-1:0]        IDX_LAST = IDX_W'(SIDE - 1);
    localparam logic [IDX_W-1:0]        IDX_ONE  = IDX_W'(1);
    localparam logic signed [MAG_W-1:0] MAG_RST  = MAG_W'(CELLS);
    localparam logic signed [ENG_W-1:0] ENG_RST  = ENG_W'(-2 * CELLS);
    localparam logic signed [MAG_W-1:0] MAG_STEP = MAG_W'(2);

    // Controller and item registers
    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_clr_row;
    logic [IDX_W-1:0]    r_row;
    logic [IDX_W-1:0]    r_col;
    logic [FRAC_W-1:0]   r_rnd;
    logic                r_up_bit;
    logic                r_dn_bit;
    logic [FRAC_W-1:0]   r_frac_de4;
    logic [FRAC_W-1:0]   r_frac_de8;
    logic signed [MAG_W-1:0] r_mag;
    logic signed [ENG_W-1:0] r_eng;
    logic                r_out_valid;

    // Memory controls
    logic                w_rd_en_a, w_rd_en_b, w_wr_en;
    logic [IDX_W-1:0]    w_rd_addr_a, w_rd_addr_b, w_wr_addr;
    logic [SIDE-1:0]     w_rd_data_a, w_rd_data_b, w_wr_data;

    logic [IDX_W-1:0]    w_wrap_tbl [SITE_CODES];
    logic [IDX_W-1:0]    w_in_row, w_in_col, w_row_up, w_row_dn;
    logic [IDX_W-1:0]    w_col_left, w_col_right;
    logic                w_accept_in;
    logic                w_load;
    logic [SIDE-1:0]     w_new_row;
    t_eval               w_eval;
    logic signed [MAG_W-1:0] w_mag_next;
    logic signed [ENG_W-1:0] w_eng_next;

    // Site index modulo SIDE as a constant table
    for (genvar gi = 0; gi < SITE_CODES; gi++) begin : g_wrap
        assign w_wrap_tbl[gi] = IDX_W'(gi % SIDE);
    end

    // Wrapped neighbor indexes
    always_comb begin
        w_in_row    = w_wrap_tbl[i_site_row];
        w_in_col    = w_wrap_tbl[i_site_col];
        w_row_up    = (w_in_row == '0) ? IDX_LAST : w_in_row - IDX_ONE;
        w_row_dn    = (w_in_row == IDX_LAST) ? '0 : w_in_row + IDX_ONE;
        w_col_left  = (r_col == '0) ? IDX_LAST : r_col - IDX_ONE;
        w_col_right = (r_col == IDX_LAST) ? '0 : r_col + IDX_ONE;
    end

    ising_lattice_mem #(
        .SIDE  (SIDE),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rd_en_a   (w_rd_en_a),
        .i_rd_addr_a (w_rd_addr_a),
        .o_rd_data_a (w_rd_data_a),
        .i_rd_en_b   (w_rd_en_b),
        .i_rd_addr_b (w_rd_addr_b),
        .o_rd_data_b (w_rd_data_b),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data)
    );

    // Port A holds the site's own row during evaluation
    ising_flip_eval u_eval (
        .i_spin     (w_rd_data_a[r_col]),
        .i_up       (r_up_bit),
        .i_down     (r_dn_bit),
        .i_left     (w_rd_data_a[w_col_left]),
        .i_right    (w_rd_data_a[w_col_right]),
        .i_rnd      (r_rnd),
        .i_frac_de4 (r_frac_de4),
        .i_frac_de8 (r_frac_de8),
        .o_eval     (w_eval)
    );

    // Updated row and running totals
    always_comb begin
        w_new_row        = w_rd_data_a;
        w_new_row[r_col] = w_eval.spin_after;
        w_mag_next       = r_mag;
        w_eng_next       = r_eng;
        if (w_eval.flip) begin
            w_mag_next = w_eval.spin_after ? r_mag + MAG_STEP : r_mag - MAG_STEP;
            w_eng_next = r_eng + ENG_W'(w_eval.de);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_row == IDX_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_READ_CTR;
                end
            end
            ST_READ_CTR: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (!r_out_valid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // State outputs: handshake and memory access
    always_comb begin
        o_ready     = 1'b0;
        w_load      = 1'b0;
        w_rd_en_a   = 1'b0;
        w_rd_en_b   = 1'b0;
        w_rd_addr_a = w_row_up;
        w_rd_addr_b = w_row_dn;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_row;
        w_wr_data   = w_new_row;
        case (r_state)
            ST_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_row;
                w_wr_data = '1;
            end
            ST_IDLE: begin
                o_ready   = 1'b1;
                w_rd_en_a = i_valid;
                w_rd_en_b = i_valid;
            end
            ST_READ_CTR: begin
                w_rd_en_a   = 1'b1;
                w_rd_addr_a = r_row;
            end
            ST_EVAL: begin
                w_load  = !r_out_valid || i_ready;
                w_wr_en = w_load && w_eval.flip;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign w_accept_in = i_valid && o_ready;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_row   <= '0;
            r_out_valid <= 1'b0;
            r_mag       <= MAG_RST;
            r_eng       <= ENG_RST;
            r_frac_de4  <= FRAC_DE4_RST;
            r_frac_de8  <= FRAC_DE8_RST;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_row <= r_clr_row + IDX_ONE;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_mag       <= w_mag_next;
                r_eng       <= w_eng_next;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DE4: r_frac_de4 <= i_cfg_data;
                    CFG_DE8: r_frac_de8 <= i_cfg_data;
                    default: r_frac_de4 <= r_frac_de4;
                endcase
            end
        end
    end

    // Item registers
    always_ff @(posedge i_clk) begin
        if (w_accept_in) begin
            r_row <= w_in_row;
            r_col <= w_in_col;
            r_rnd <= i_random_fraction;
        end
        if (r_state == ST_READ_CTR) begin
            r_up_bit <= w_rd_data_a[r_col];
            r_dn_bit <= w_rd_data_b[r_col];
        end
        if (w_load) begin
            o_flipped       <= w_eval.flip;
            o_spin_after    <= w_eval.spin_after;
            o_energy_change <= w_eval.de;
            o_magnetization <= w_mag_next;
            o_total_energy  <= w_eng_next;
        end
    end

    assign o_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    // Totals move only when a flip is loaded into the result word
    a_totals_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_load && w_eval.flip) |=> ($stable(r_mag) && $stable(r_eng)))
        else $error("running totals changed without a flip");

    // Every energy step is a multiple of four, every magnetization step two
    a_total_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_eng[1:0] == ENG_RST[1:0]) && (r_mag[0] == MAG_RST[0]))
        else $error("running total parity broken");

    // A result word appears only out of the evaluate step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == ST_EVAL))
        else $error("result word raised outside evaluation");
`endif

endmodule

`default_nettype wire

// ===== dv/ising_flip_checker.sv =====
// Scoreboard for the Ising site-update block: predicts each result word from the
// visited site and compares it with what comes out. Depends on ising_pkg.
`timescale 1ns / 1ps

module ising_flip_checker
    import ising_pkg::*;
#(
    parameter int SIDE = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration port, watched
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [FRAC_W-1:0]    i_cfg_data,
    // Site words, watched
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [SITE_W-1:0]    i_site_row,
    input  logic [SITE_W-1:0]    i_site_col,
    input  logic [FRAC_W-1:0]    i_random_fraction,
    // Result words, watched
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_flipped,
    input  logic                 i_spin_after,
    input  logic signed [DE_W-1:0]  i_energy_change,
    input  logic signed [MAG_W-1:0] i_magnetization,
    input  logic signed [ENG_W-1:0] i_total_energy,
    // Status to the test top
    output int                   o_pending,
    output int                   o_fail_count
);

    typedef struct packed {
        logic                    flipped;
        logic                    spin_after;
        logic signed [DE_W-1:0]  energy_change;
        logic signed [MAG_W-1:0] magnetization;
        logic signed [ENG_W-1:0] total_energy;
    } t_visit_result;

    // Shadow of the lattice and the running totals; 1 means spin +1
    bit                  spins [SIDE*SIDE];
    int                  mag_total;
    int                  energy_total;
    logic [FRAC_W-1:0]   frac_de4;
    logic [FRAC_W-1:0]   frac_de8;

    t_visit_result       visit_results_q [$];
    int                  mismatches = 0;

    function automatic int spin_at(int row, int col);
        return spins[row * SIDE + col] ? 1 : -1;
    endfunction

    // Metropolis step on the shadow lattice; returns the word the block should send
    function automatic t_visit_result visit_site(input logic [SITE_W-1:0] row,
                                                 input logic [SITE_W-1:0] col,
                                                 input logic [FRAC_W-1:0] draw);
        int            r;
        int            c;
        int            spin;
        int            nbr_sum;
        int            de;
        bit            take;
        t_visit_result res;
        r = int'(row) % SIDE;
        c = int'(col) % SIDE;
        spin = spin_at(r, c);
        nbr_sum = spin_at((r + SIDE - 1) % SIDE, c) + spin_at((r + 1) % SIDE, c)
                + spin_at(r, (c + SIDE - 1) % SIDE) + spin_at(r, (c + 1) % SIDE);
        de = 2 * spin * nbr_sum;
        if (de <= 0)
            take = 1'b1;
        else if (de == int'(DE_FOUR))
            take = draw < frac_de4;
        else
            take = draw < frac_de8;
        if (take) begin
            spin = -spin;
            spins[r * SIDE + c] = (spin > 0);
            mag_total += 2 * spin;
            energy_total += de;
        end
        res.flipped       = take;
        res.spin_after    = (spin > 0);
        res.energy_change = de[DE_W-1:0];
        res.magnetization = mag_total[MAG_W-1:0];
        res.total_energy  = energy_total[ENG_W-1:0];
        return res;
    endfunction

    function automatic void check_field(string name, logic signed [ENG_W-1:0] want,
                                        logic signed [ENG_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Track reset and config, retire result words, then queue new predictions
    always @(posedge i_clk) begin : watch
        t_visit_result want;
        if (!i_rst_n) begin
            foreach (spins[k])
                spins[k] = 1'b1;
            mag_total    = SIDE * SIDE;
            energy_total = -2 * SIDE * SIDE;
            frac_de4     = FRAC_DE4_RST;
            frac_de8     = FRAC_DE8_RST;
            visit_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DE4)
                    frac_de4 = i_cfg_data;
                else if (i_cfg_index == CFG_DE8)
                    frac_de8 = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (visit_results_q.size() == 0) begin
                    $error("result word with no site visit pending");
                    mismatches++;
                end else begin
                    want = visit_results_q.pop_front();
                    check_field("flipped", want.flipped, i_flipped);
                    check_field("spin_after", want.spin_after, i_spin_after);
                    check_field("energy_change", want.energy_change, i_energy_change);
                    check_field("magnetization", want.magnetization, i_magnetization);
                    check_field("total_energy", want.total_energy, i_total_energy);
                end
            end
            if (i_in_valid && i_in_ready)
                visit_results_q.push_back(visit_site(i_site_row, i_site_col,
                                                     i_random_fraction));
        end
        o_pending    <= visit_results_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== dv/tb_ising_metropolis_site_update.sv =====
// Test top for ising_metropolis_site_update: drives site words in bursts, stalls
// the result side, sweeps the acceptance fractions. Depends on ising_pkg, ising_flip_checker.
`timescale 1ns / 1ps

module tb_ising_metropolis_site_update;
    import ising_pkg::*;

    localparam int SIDE        = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_WORDS = 150;
    localparam int N_SWEEPS    = 6;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic                    i_cfg_index = CFG_DE4;
    logic [FRAC_W-1:0]       i_cfg_data = '0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic [SITE_W-1:0]       i_site_row = '0;
    logic [SITE_W-1:0]       i_site_col = '0;
    logic [FRAC_W-1:0]       i_random_fraction = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic                    o_flipped;
    logic                    o_spin_after;
    logic signed [DE_W-1:0]  o_energy_change;
    logic signed [MAG_W-1:0] o_magnetization;
    logic signed [ENG_W-1:0] o_total_energy;

    int                      pending_results;
    int                      fail_count;
    int                      idle_cycles = 0;

    // Current acceptance fractions, kept to aim draws at the thresholds
    logic [FRAC_W-1:0]       cur_de4 = FRAC_DE4_RST;
    logic [FRAC_W-1:0]       cur_de8 = FRAC_DE8_RST;

    logic [3:0]              stall_step = '0;
    logic [15:0]             ready_mask = '1;

    // Fraction sweep: extremes first, then mixed and random settings
    logic [FRAC_W-1:0]       sweep_de4 [N_SWEEPS] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0,
                                                      16'd30000, 16'd0};
    logic [FRAC_W-1:0]       sweep_de8 [N_SWEEPS] = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF,
                                                      16'd4000, 16'd0};

    always #10 i_clk = ~i_clk;

    ising_metropolis_site_update #(.SIDE(SIDE)) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_site_row        (i_site_row),
        .i_site_col        (i_site_col),
        .i_random_fraction (i_random_fraction),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_flipped         (o_flipped),
        .o_spin_after      (o_spin_after),
        .o_energy_change   (o_energy_change),
        .o_magnetization   (o_magnetization),
        .o_total_energy    (o_total_energy)
    );

    ising_flip_checker #(.SIDE(SIDE)) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_valid),
        .i_in_ready        (o_ready),
        .i_site_row        (i_site_row),
        .i_site_col        (i_site_col),
        .i_random_fraction (i_random_fraction),
        .i_out_valid       (o_valid),
        .i_out_ready       (i_ready),
        .i_flipped         (o_flipped),
        .i_spin_after      (o_spin_after),
        .i_energy_change   (o_energy_change),
        .i_magnetization   (o_magnetization),
        .i_total_energy    (o_total_energy),
        .o_pending         (pending_results),
        .o_fail_count      (fail_count)
    );

    // Result side: stall on a 16-bit ready mask, reshuffled every pass; some passes never stall
    always @(posedge i_clk) begin
        stall_step <= stall_step + 4'd1;
        i_ready    <= ready_mask[stall_step];
        if (stall_step == 4'd15) begin
            if ($urandom_range(0, 2) == 0)
                ready_mask <= '1;
            else
                ready_mask <= 16'($urandom()) | 16'h0001;
        end
    end

    // Present one site word and hold it until accepted; valid stays high on return
    task automatic offer_site(input logic [SITE_W-1:0] row, input logic [SITE_W-1:0] col,
                              input logic [FRAC_W-1:0] draw);
        i_valid           <= 1'b1;
        i_site_row        <= row;
        i_site_col        <= col;
        i_random_fraction <= draw;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    // Wait until every predicted result word has come back, then let the pipe settle
    task automatic drain_results();
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_fractions(input logic [FRAC_W-1:0] de4,
                                   input logic [FRAC_W-1:0] de8);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DE4;
        i_cfg_data  <= de4;
        @(posedge i_clk);
        i_cfg_index <= CFG_DE8;
        i_cfg_data  <= de8;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_de4 = de4;
        cur_de8 = de8;
    endtask

    // Random site visits in bursts with gaps; draws cluster around the thresholds
    task automatic run_sweep_phase(input int count);
        int                sent;
        int                burst;
        logic [FRAC_W-1:0] draw;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 16);
            for (int k = 0; k < burst && sent < count; k++) begin
                case ($urandom_range(0, 7))
                    0: draw = cur_de4 - 16'd1;
                    1: draw = cur_de4;
                    2: draw = cur_de8 - 16'd1;
                    3: draw = cur_de8;
                    4: draw = '0;
                    5: draw = '1;
                    default: draw = 16'($urandom());
                endcase
                offer_site(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), draw);
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
    endtask

    // Stall watchdog: end the run when nothing moves for too long
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("ising_metropolis_site_update regression: fail");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed visits at reset fractions: corner wraps, dE -8, 0, 4 and 8, draws
        // just below and at each threshold, full-scale draws
        offer_site(4'd0, 4'd0, 16'd21);        // dE 8, accepted just below threshold
        offer_site(4'd0, 4'd0, 16'd0);         // dE -8, always accepted
        offer_site(4'd0, 4'd0, 16'd22);        // dE 8, rejected at threshold
        offer_site(4'd15, 4'd15, 16'hFFFF);    // corner, rejected
        offer_site(4'd15, 4'd15, 16'd0);       // corner flips
        offer_site(4'd0, 4'd15, 16'd1199);     // dE 4 across the wrap, accepted
        offer_site(4'd15, 4'd0, 16'd1200);     // dE 4, rejected at threshold
        offer_site(4'd0, 4'd0, 16'd0);         // dE 4, accepted
        offer_site(4'd15, 4'd0, 16'hFFFF);     // dE 0, accepted regardless of draw
        offer_site(4'd15, 4'd0, 16'h5555);
        offer_site(4'd7, 4'd8, 16'hAAAA);
        offer_site(4'd8, 4'd7, 16'h0001);
        offer_site(4'd0, 4'd1, 16'h8000);
        offer_site(4'd1, 4'd0, 16'h7FFF);
        i_valid <= 1'b0;
        drain_results();

        // Fraction sweep with random visits, lattice carried across phases
        for (int p = 0; p < N_SWEEPS; p++) begin
            if (p == N_SWEEPS - 1)
                write_fractions(16'($urandom()), 16'($urandom()));
            else
                write_fractions(sweep_de4[p], sweep_de8[p]);
            run_sweep_phase(PHASE_WORDS);
            drain_results();
        end

        if (fail_count == 0)
            $display("ising_metropolis_site_update regression: pass");
        else
            $display("ising_metropolis_site_update regression: fail");
        $finish;
    end

endmodule
